// ===== sv/rsrp_pkg.sv =====
`timescale 1ns / 1ps

package rsrp_pkg;

    // Number of input fields and their width.
    localparam int unsigned FieldW = 64;
    localparam int unsigned DataW  = 6 * FieldW;

    // Smallest accepted magnitude of n.dir.
    localparam logic [63:0] EpsRaw = 64'd42949;

    // Register addresses (byte addresses, 8 bytes apart).
    localparam logic [5:0] AddrInner   = 6'd0;
    localparam logic [5:0] AddrOuter   = 6'd8;
    localparam logic [5:0] AddrNormalX = 6'd16;
    localparam logic [5:0] AddrNormalY = 6'd24;
    localparam logic [5:0] AddrNormalZ = 6'd32;

    // Reset value of the normal z component: 1.0 in Q32.32.
    localparam logic [63:0] NormalZReset = 64'h0000_0001_0000_0000;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [62:0] inner_sq;
        logic [62:0] outer_sq;
        logic [63:0] nx;
        logic [63:0] ny;
        logic [63:0] nz;
    } t_cfg;

    // Partial products of one Q32.32 multiply, plus the sign fix-up term.
    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
        logic [31:0] fix;
    } t_part;

    // First multiply stage: four unsigned 32 x 32 products. Only the low
    // half of the sign correction matters since it lands at bit 32.
    function automatic t_part mul_part(input logic [63:0] a, input logic [63:0] b);
        t_part p;
        p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
        p.p01 = 64'(a[31:0]) * 64'(b[63:32]);
        p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
        p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
        p.fix = (a[63] ? b[31:0] : 32'd0) + (b[63] ? a[31:0] : 32'd0);
        return p;
    endfunction

    // Second multiply stage: bits 32..95 of the signed 128-bit product.
    function automatic logic [63:0] mul_join(input t_part p);
        return {p.p11[31:0], 32'd0} + p.p01 + p.p10 + {32'd0, p.p00[63:32]}
               - {p.fix, 32'd0};
    endfunction

endpackage

// ===== sv/rsrp_cfg.sv =====
`timescale 1ns / 1ps

module rsrp_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output rsrp_pkg::t_cfg    o_cfg
);

    rsrp_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inner_sq <= '0;
            r_cfg.outer_sq <= '0;
            r_cfg.nx       <= '0;
            r_cfg.ny       <= '0;
            r_cfg.nz       <= rsrp_pkg::NormalZReset;
        end else if (w_wr) begin
            unique case (paddr)
                rsrp_pkg::AddrInner:   r_cfg.inner_sq <= pwdata[62:0];
                rsrp_pkg::AddrOuter:   r_cfg.outer_sq <= pwdata[62:0];
                rsrp_pkg::AddrNormalX: r_cfg.nx       <= pwdata;
                rsrp_pkg::AddrNormalY: r_cfg.ny       <= pwdata;
                rsrp_pkg::AddrNormalZ: r_cfg.nz       <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (paddr)
            rsrp_pkg::AddrInner:   prdata = {1'b0, r_cfg.inner_sq};
            rsrp_pkg::AddrOuter:   prdata = {1'b0, r_cfg.outer_sq};
            rsrp_pkg::AddrNormalX: prdata = r_cfg.nx;
            rsrp_pkg::AddrNormalY: prdata = r_cfg.ny;
            rsrp_pkg::AddrNormalZ: prdata = r_cfg.nz;
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== sv/rsrp_div.sv =====
`timescale 1ns / 1ps

// Pipelined unsigned restoring divider of a 96-bit dividend by a 64-bit
// divisor, one quotient bit per stage. Side bits travel alongside.
module rsrp_div #(
    parameter int unsigned SideW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [95:0]      i_num,
    input  logic [63:0]      i_den,
    input  logic [SideW-1:0] i_side,
    output logic             o_valid,
    output logic [63:0]      o_quot,
    output logic [SideW-1:0] o_side
);

    localparam int unsigned Steps = 96;

    logic                 r_vld  [Steps+1];
    logic [95:0]          r_num  [Steps+1];
    logic [64:0]          r_rem  [Steps+1];
    logic [63:0]          r_den  [Steps+1];
    logic [SideW-1:0]     r_side [Steps+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_num[0]  = i_num;
        r_rem[0]  = '0;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic [64:0] w_sh;
        logic [65:0] w_diff;
        // Shift in the next dividend bit and try the subtraction.
        assign w_sh   = {r_rem[s][63:0], r_num[s][95]};
        assign w_diff = {1'b0, w_sh} - {2'b0, r_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= w_diff[65] ? w_sh : w_diff[64:0];
                r_num[s+1]  <= {r_num[s][94:0], ~w_diff[65]};
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_vld[Steps];
    assign o_quot  = r_num[Steps][63:0];
    assign o_side  = r_side[Steps];

endmodule

// ===== sv/ring_shadow_ray_plane_test.sv =====
`timescale 1ns / 1ps

// Ring shadow test. Each request on the slave stream carries a sample
// position and a light direction (six signed Q32.32 values). The block
// answers with one bit on the master stream: 1 when the ray from the
// sample toward the light misses the ring in the plane through the origin
// with normal n, 0 when it crosses the ring between the inner and outer
// radius. Ring radii and normal are set through the APB port at byte
// addresses 0, 8, 16, 24 and 32; the user must write them only while no
// request is in flight; the block leaves this unchecked. Throughput is
// one request per cycle unless the master stalls. In order, there are
// four stages for the dot products and epsilon test (two per multiply,
// one for the sums, one for the magnitudes), one quotient bit per stage
// through a 96-stage divider, one stage for t, two for the hit point, two
// for the squares, one for the squared distance, and the output register.
// Reset empties the pipeline and loads the registers with their defaults
// (normal = +z). A stall on the master side freezes the whole pipeline;
// tready on the slave side drops only while the output register is full
// and not taken, so nothing is lost or repeated.
module ring_shadow_ray_plane_test (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_x, sample_y, sample_z, light_dir_x, light_dir_y, light_dir_z
    input  logic [383:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // lit, then seven zero bits
    output logic [7:0]   m_axis_tdata
);

    rsrp_pkg::t_cfg w_cfg;

    rsrp_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    // Whole pipeline advances unless the output register holds a result
    // that is not taken.
    logic w_en;
    logic r_ov;
    logic r_olit;
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    logic [63:0] w_px, w_py, w_pz, w_dx, w_dy, w_dz;
    assign w_px = s_axis_tdata[63:0];
    assign w_py = s_axis_tdata[127:64];
    assign w_pz = s_axis_tdata[191:128];
    assign w_dx = s_axis_tdata[255:192];
    assign w_dy = s_axis_tdata[319:256];
    assign w_dz = s_axis_tdata[383:320];

    // Stage 1: partial products of the six dot product terms.
    logic            r1_v;
    logic [383:0]    r1_d;
    rsrp_pkg::t_part r1_a, r1_b, r1_c, r1_e, r1_f, r1_g;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d <= s_axis_tdata;
            r1_a <= rsrp_pkg::mul_part(w_cfg.nx, w_dx);
            r1_b <= rsrp_pkg::mul_part(w_cfg.ny, w_dy);
            r1_c <= rsrp_pkg::mul_part(w_cfg.nz, w_dz);
            r1_e <= rsrp_pkg::mul_part(w_cfg.nx, w_px);
            r1_f <= rsrp_pkg::mul_part(w_cfg.ny, w_py);
            r1_g <= rsrp_pkg::mul_part(w_cfg.nz, w_pz);
        end
    end

    // Stage 2: the six Q32.32 products.
    logic         r2_v;
    logic [383:0] r2_d;
    logic [63:0]  r2_a, r2_b, r2_c, r2_e, r2_f, r2_g;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_d <= r1_d;
            r2_a <= rsrp_pkg::mul_join(r1_a);
            r2_b <= rsrp_pkg::mul_join(r1_b);
            r2_c <= rsrp_pkg::mul_join(r1_c);
            r2_e <= rsrp_pkg::mul_join(r1_e);
            r2_f <= rsrp_pkg::mul_join(r1_f);
            r2_g <= rsrp_pkg::mul_join(r1_g);
        end
    end

    // Stage 3: sums give denom and num = -(n.pos).
    logic         r3_v;
    logic [383:0] r3_d;
    logic [63:0]  r3_den, r3_num;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_d   <= r2_d;
            r3_den <= r2_a + r2_b + r2_c;
            r3_num <= 64'd0 - (r2_e + r2_f + r2_g);
        end
    end

    // Stage 4: magnitudes, signs and the epsilon test.
    logic         r4_v;
    logic [383:0] r4_d;
    logic [63:0]  r4_nmag, r4_dmag;
    logic         r4_qneg, r4_lit;
    logic [63:0]  w_dmag;
    assign w_dmag = r3_den[63] ? 64'd0 - r3_den : r3_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_d    <= r3_d;
            r4_nmag <= r3_num[63] ? 64'd0 - r3_num : r3_num;
            // Keep the divisor nonzero when the item is lit early.
            r4_dmag <= (w_dmag[63] || w_dmag < rsrp_pkg::EpsRaw) ? 64'd1 : w_dmag;
            r4_qneg <= r3_num[63] ^ r3_den[63];
            r4_lit  <= w_dmag[63] || (w_dmag < rsrp_pkg::EpsRaw);
        end
    end

    // Divider: side bits carry the early flag, quotient sign and the
    // position and direction.
    localparam int unsigned SideW = 2 + 6 * 64;
    logic             w_qv;
    logic [63:0]      w_qmag;
    logic [SideW-1:0] w_qside;
    rsrp_div #(.SideW(SideW)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4_v),
        .i_num({r4_nmag, 32'd0}), .i_den(r4_dmag),
        .i_side({r4_lit, r4_qneg, r4_d}),
        .o_valid(w_qv), .o_quot(w_qmag), .o_side(w_qside)
    );

    // Stage 5: signed t and early decision.
    logic         r5_v, r5_lit;
    logic [63:0]  r5_t;
    logic [383:0] r5_d;
    logic [63:0]  w_t;
    assign w_t = w_qside[384] ? 64'd0 - w_qmag : w_qmag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= w_qv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_t   <= w_t;
            r5_lit <= w_qside[385] || w_t[63];
            r5_d   <= w_qside[383:0];
        end
    end

    // Stage 6: partial products of dir * t.
    logic            r6_v, r6_lit;
    logic [63:0]     r6_px, r6_py, r6_pz;
    rsrp_pkg::t_part r6_mx, r6_my, r6_mz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (w_en) r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_lit <= r5_lit;
            r6_px  <= r5_d[63:0];
            r6_py  <= r5_d[127:64];
            r6_pz  <= r5_d[191:128];
            r6_mx  <= rsrp_pkg::mul_part(r5_d[255:192], r5_t);
            r6_my  <= rsrp_pkg::mul_part(r5_d[319:256], r5_t);
            r6_mz  <= rsrp_pkg::mul_part(r5_d[383:320], r5_t);
        end
    end

    // Stage 7: hit point.
    logic        r7_v, r7_lit;
    logic [63:0] r7_hx, r7_hy, r7_hz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (w_en) r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_lit <= r6_lit;
            r7_hx  <= r6_px + rsrp_pkg::mul_join(r6_mx);
            r7_hy  <= r6_py + rsrp_pkg::mul_join(r6_my);
            r7_hz  <= r6_pz + rsrp_pkg::mul_join(r6_mz);
        end
    end

    // Stage 8: partial products of the squares.
    logic            r8_v, r8_lit;
    rsrp_pkg::t_part r8_sx, r8_sy, r8_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (w_en) r8_v <= r7_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_lit <= r7_lit;
            r8_sx  <= rsrp_pkg::mul_part(r7_hx, r7_hx);
            r8_sy  <= rsrp_pkg::mul_part(r7_hy, r7_hy);
            r8_sz  <= rsrp_pkg::mul_part(r7_hz, r7_hz);
        end
    end

    // Stage 9: squares.
    logic        r9_v, r9_lit;
    logic [63:0] r9_sx, r9_sy, r9_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (w_en) r9_v <= r8_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_lit <= r8_lit;
            r9_sx  <= rsrp_pkg::mul_join(r8_sx);
            r9_sy  <= rsrp_pkg::mul_join(r8_sy);
            r9_sz  <= rsrp_pkg::mul_join(r8_sz);
        end
    end

    // Stage 10: squared distance.
    logic        r10_v, r10_lit;
    logic [63:0] r10_dist;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (w_en) r10_v <= r9_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_lit  <= r9_lit;
            r10_dist <= r9_sx + r9_sy + r9_sz;
        end
    end

    // Output register: range test against the ring radii.
    logic w_in_ring;
    assign w_in_ring = !r10_dist[63] && (r10_dist[62:0] >= w_cfg.inner_sq)
                       && (r10_dist[62:0] <= w_cfg.outer_sq);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r10_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_olit <= r10_lit || !w_in_ring;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_olit};

endmodule

// ===== sv/rsrp_checker.sv =====
`timescale 1ns / 1ps

module rsrp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       pready
);

    // A held result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // Input side is ready whenever the output register is free.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free output register");

    // Padding bits of the result stay zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("nonzero padding in result");

    // Nothing comes out right after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Configuration port never waits.
    a_apb: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind ring_shadow_ray_plane_test rsrp_checker u_rsrp_checker (
    .i_clk, .i_rst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .pready
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CycleLimit = 400000;

    // Shadow test predictor with its own copy of the ring configuration.
    class ring_scoreboard;
        logic [62:0] inner_sq;
        logic [62:0] outer_sq;
        logic [63:0] nx, ny, nz;
        bit          lit_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned shadowed;

        function new();
            inner_sq = '0;
            outer_sq = '0;
            nx = '0;
            ny = '0;
            nz = rsrp_pkg::NormalZReset;
            errors = 0;
            checked = 0;
            shadowed = 0;
        endfunction

        // Q32.32 product, keeping bits 32..95 of the full signed product.
        function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
            logic signed [127:0] p;
            p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
            return p[95:32];
        endfunction

        function logic [63:0] qdot(logic [63:0] ax, logic [63:0] ay, logic [63:0] az,
                                   logic [63:0] bx, logic [63:0] by, logic [63:0] bz);
            return qmul(ax, bx) + qmul(ay, by) + qmul(az, bz);
        endfunction

        // (num << 32) / den, truncated toward zero, wrapped to 64 bits.
        function logic [63:0] qdiv(logic [63:0] num, logic [63:0] den);
            logic [63:0]  nm, dm, q;
            logic [127:0] quo;
            nm = num[63] ? -num : num;
            dm = den[63] ? -den : den;
            quo = {32'd0, nm, 32'd0} / {64'd0, dm};
            q = quo[63:0];
            return (num[63] ^ den[63]) ? -q : q;
        endfunction

        function bit ring_lit(logic [383:0] d);
            logic [63:0] px, py, pz, dx, dy, dz;
            logic [63:0] denom, mag, t, hx, hy, hz, dist_sq;
            px = d[63:0];    py = d[127:64];  pz = d[191:128];
            dx = d[255:192]; dy = d[319:256]; dz = d[383:320];
            denom = qdot(nx, ny, nz, dx, dy, dz);
            mag = denom[63] ? -denom : denom;
            // A most negative denominator wraps to itself and counts as tiny.
            if ($signed(mag) < $signed(rsrp_pkg::EpsRaw)) return 1'b1;
            t = qdiv(-qdot(nx, ny, nz, px, py, pz), denom);
            if (t[63]) return 1'b1;
            hx = px + qmul(dx, t);
            hy = py + qmul(dy, t);
            hz = pz + qmul(dz, t);
            dist_sq = qdot(hx, hy, hz, hx, hy, hz);
            if ($signed(dist_sq) >= $signed({1'b0, inner_sq}) &&
                $signed(dist_sq) <= $signed({1'b0, outer_sq})) return 1'b0;
            return 1'b1;
        endfunction

        function void note_request(logic [383:0] d);
            lit_q.push_back(ring_lit(d));
        endfunction

        function void check_result(logic [7:0] data);
            bit exp_lit;
            if (lit_q.size() == 0) begin
                $error("unexpected result, lit=%0d", data[0]);
                errors++;
                return;
            end
            exp_lit = lit_q.pop_front();
            checked++;
            if (!exp_lit) shadowed++;
            if (data[0] !== exp_lit) begin
                $error("lit mismatch: expected %0d, actual %0d", exp_lit, data[0]);
                errors++;
            end
            if (data[7:1] !== 7'd0) begin
                $error("pad mismatch: expected 0, actual %0h", data[7:1]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         psel, penable, pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // sample_x, sample_y, sample_z, light_dir_x, light_dir_y, light_dir_z
    logic [383:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // lit, then seven zero bits
    logic [7:0]   m_axis_tdata;

    ring_scoreboard sb;
    int unsigned    cycles;
    int unsigned    burst_left;

    ring_shadow_ray_plane_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: stall mode follows bits 7:6 of the cycle counter.
    always @(posedge i_clk) begin
        case ((cycles >> 6) % 4)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
                m_axis_tready <= cycles[1];
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 9) < 2);
            end
        endcase
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input logic [5:0] addr, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            rsrp_pkg::AddrInner:   sb.inner_sq = value[62:0];
            rsrp_pkg::AddrOuter:   sb.outer_sq = value[62:0];
            rsrp_pkg::AddrNormalX: sb.nx = value;
            rsrp_pkg::AddrNormalY: sb.ny = value;
            default:               sb.nz = value;
        endcase
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ring(input logic [63:0] inner, input logic [63:0] outer,
                            input logic [63:0] x, input logic [63:0] y,
                            input logic [63:0] z);
        // Stop sending, then let the pipeline drain before writing.
        idle_sender();
        while (sb.lit_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(rsrp_pkg::AddrInner, inner);
        write_reg(rsrp_pkg::AddrOuter, outer);
        write_reg(rsrp_pkg::AddrNormalX, x);
        write_reg(rsrp_pkg::AddrNormalY, y);
        write_reg(rsrp_pkg::AddrNormalZ, z);
    endtask

    // Send one request, with burst gaps between groups of requests.
    task automatic send_request(input logic [383:0] d);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(d);
    endtask

    // Small signed Q32.32 value with integer part in [-mag, mag].
    function automatic logic [63:0] small_q(int mag);
        longint ip;
        ip = longint'($urandom_range(0, 2 * mag)) - mag;
        return (ip <<< 32) + longint'($urandom);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [383:0] pack6(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                          logic [63:0] d, logic [63:0] e, logic [63:0] f);
        return {f, e, d, c, b, a};
    endfunction

    // Mostly rays that can cross the ring, the rest raw noise.
    function automatic logic [383:0] ring_ray(int mag);
        if ($urandom_range(0, 9) < 8)
            return pack6(small_q(mag), small_q(mag), small_q(mag),
                         small_q(mag), small_q(mag), small_q(mag));
        return pack6(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
    endfunction

    localparam logic [63:0] One   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] MaxP  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MinN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] Ones  = 64'hFFFF_FFFF_FFFF_FFFF;

    initial begin
        sb = new();
        cycles = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: empty-width ring at the origin.
        send_request(pack6(0, 0, One, 0, 0, -One));
        send_request(pack6(0, 0, 0, 0, 0, 0));

        // Ring of squared radius 1..16 in the z = 0 plane.
        set_ring(One, 16 * One, 0, 0, One);
        send_request(pack6(2 * One, 0, One, 0, 0, -One));             // hits ring
        send_request(pack6(0, 0, One, 0, 0, -One));                   // through the hole
        send_request(pack6(One, 0, One, 0, 0, -One));                 // inner edge
        send_request(pack6(4 * One, 0, One, 0, 0, -One));             // outer edge
        send_request(pack6(8 * One, 0, One, 0, 0, -One));             // outside
        send_request(pack6(2 * One, 0, One, 0, 0, One));              // negative t
        send_request(pack6(2 * One, 0, One, One, 0, 0));              // parallel
        send_request(pack6(2 * One, 0, One, 0, 0, -64'sd42948));      // just below epsilon
        send_request(pack6(2 * One, 0, One, 0, 0, -64'sd42949));      // at epsilon
        send_request(pack6(0, 0, 0, 0, 0, MinN));
        send_request(pack6(MaxP, MaxP, MaxP, MaxP, MaxP, MaxP));
        send_request(pack6(MinN, MinN, MinN, MinN, MinN, MinN));
        send_request(pack6(Ones, Ones, Ones, Ones, Ones, Ones));
        send_request(pack6(2 * One, One, MinN, 0, 0, -One));           // distance wraps

        // Normal of most negative z: |denom| wraps and stays negative.
        set_ring(0, MaxP, 0, 0, MinN);
        send_request(pack6(2 * One, 0, One, 0, 0, One));
        send_request(pack6(2 * One, 0, One, 0, 0, -One));
        // Inner radius above outer: the ring is empty.
        set_ring(MaxP, One, 0, 0, One);
        send_request(pack6(2 * One, 0, One, 0, 0, -One));
        send_request(pack6(0, 0, 0, 0, 0, -One));

        // Random phases over several ring settings.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_ring(One, 16 * One, 0, 0, One);
                1: set_ring(small_q(2) & MaxP, 64 * One, small_q(2), small_q(2), small_q(2));
                2: set_ring(0, MaxP, small_q(4), small_q(4), small_q(4));
                3: set_ring(rand64(), rand64(), rand64(), rand64(), rand64());
                4: set_ring(4 * One, 9 * One, One, 0, 0);
                default: set_ring(Ones, Ones, MaxP, MinN, Ones);
            endcase
            for (int k = 0; k < 340; k++) begin
                send_request(ring_ray(phase == 2 ? 1000 : 6));
            end
            idle_sender();
        end

        while (sb.lit_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d shadow decisions (%0d shadowed) over ten ring settings,",
                 sb.checked, sb.shadowed);
        $display("including epsilon, negative t, wrapped distance and empty ring cases.");
        if (sb.errors == 0 && sb.lit_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
